### rtl/timestamped_attitude_interpolator_core_macros.svh
// Assertion macros shared by the interpolator files.
`ifndef TIMESTAMPED_ATTITUDE_INTERPOLATOR_CORE_MACROS_SVH
`define TIMESTAMPED_ATTITUDE_INTERPOLATOR_CORE_MACROS_SVH

// Checks that an antecedent implies a consequent at the same edge.
`define TAI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that an antecedent implies a consequent at the next edge.
`define TAI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tai_pkg.sv
package tai_pkg;

   localparam logic [1:0] KIND_PUSH   = 2'd0;
   localparam logic [1:0] KIND_INTERP = 2'd1;
   localparam logic [1:0] KIND_LATEST = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic signed [17:0] Q_PI     = 18'sd25736;
   localparam logic signed [17:0] Q_TWO_PI = 18'sd51472;
   localparam logic [31:0] WINDOW_RESET    = 32'd3000000000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [62:0]        time_ns;
      logic signed [15:0] roll_in;
      logic signed [15:0] pitch_in;
      logic signed [15:0] yaw_in;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [15:0] roll_out;
      logic signed [15:0] pitch_out;
      logic signed [15:0] yaw_out;
      logic [62:0]        time_out;
      logic [31:0]        bracket_ns;
      logic [31:0]        nearest_ns;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PUSH_WR, ST_EVICT_RD, ST_EVICT_CHK, ST_LAT_RD, ST_LAT_WAIT,
      ST_Q_RD, ST_Q_CHK, ST_SCAN_RD, ST_SCAN_CHK, ST_PAIR, ST_SHIFT, ST_DIV,
      ST_BLEND, ST_WRAP, ST_OUT
   } state_type;

   // Wraps a wide angle into plus or minus pi, assuming at most one turn off.
   function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
      logic signed [17:0] r;
      r = a;
      if (r > Q_PI) r = r - Q_TWO_PI;
      else if (r < -Q_PI) r = r + Q_TWO_PI;
      return r;
   endfunction

endpackage

### rtl/tai_front.sv
`include "timestamped_attitude_interpolator_core_macros.svh"
module tai_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tai_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_take,
   output tai_pkg::req_type q_data
);
   import tai_pkg::*;

   // Two-entry queue; every kind passes through, and the back end answers
   // unused kinds with a failed response.
   req_type mem_ff [2];
   logic    wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_valid && q_take;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= req_data;
   end

   `TAI_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_take && cnt_ff == 2'd0, !pop, "pop empty")
   `TAI_ASSERT_NEXT(a_cnt_bound, clock, reset, 1'b1, cnt_ff != 2'd3, "queue overflow")
   `TAI_ASSERT_NEXT(a_cnt_track, clock, reset, push && !pop,
      cnt_ff == $past(cnt_ff) + 2'd1, "count mismatch")
endmodule

### rtl/tai_back.sv
`include "timestamped_attitude_interpolator_core_macros.svh"
module tai_back #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      window_ns,
   input  logic             q_valid,
   output logic             q_take,
   input  tai_pkg::req_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tai_pkg::rsp_type rsp_data
);
   import tai_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

   // Sample store: one write and one registered read port.
   logic [62+48:0] mem [HISTORY_DEPTH];
   logic [62+48:0] rd_ff;
   logic [AW-1:0]  raddr, waddr;
   logic           we;
   logic [110:0]   wdata;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;
   logic [AW-1:0] old_ff, old_in;
   logic [CW-1:0] cnt_ff, cnt_in, hi_ff, hi_in;
   logic [62:0] ta_ff, ta_in, tb_ff, tb_in;
   logic signed [15:0] ra_ff, ra_in, pa_ff, pa_in, ya_ff, ya_in;
   logic signed [15:0] rb_ff, rb_in, pb_ff, pb_in, yb_ff, yb_in;
   logic [62:0] den_ff, den_in, num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [5:0]  bit_ff, bit_in;
   logic signed [17:0] ro_ff, ro_in, po_ff, po_in, yo_ff, yo_in;
   rsp_type out_ff, out_in;
   logic    ov_ff, ov_in;

   logic [62:0] rd_t;
   logic signed [15:0] rd_r, rd_p, rd_y;
   assign rd_t = rd_ff[110:48];
   assign rd_r = rd_ff[47:32];
   assign rd_p = rd_ff[31:16];
   assign rd_y = rd_ff[15:0];

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] o, input logic [CW-1:0] k);
      logic [CW:0] s;
      s = {1'b0, CW'(o)} + {1'b0, k};
      if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
      return s[AW-1:0];
   endfunction

   // Blend: base + round(u*d/65536) with floor on the shifted product.
   function automatic logic signed [17:0] blend(input logic signed [15:0] a,
         input logic signed [17:0] d, input logic [16:0] u);
      logic signed [36:0] p;
      p = d * $signed({1'b0, u}) + 37'sd32768;
      return 18'(a) + 18'(p >>> 16);
   endfunction

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic [63:0] tr;
      logic [63:0] d2, nr;
      logic signed [17:0] dy;
      logic signed [17:0] yw;
      state_in = state_ff; cur_in = cur_ff; old_in = old_ff; cnt_in = cnt_ff;
      hi_in = hi_ff; ta_in = ta_ff; tb_in = tb_ff;
      ra_in = ra_ff; pa_in = pa_ff; ya_in = ya_ff;
      rb_in = rb_ff; pb_in = pb_ff; yb_in = yb_ff;
      den_in = den_ff; num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff; ro_in = ro_ff; po_in = po_ff; yo_in = yo_ff;
      out_in = out_ff; ov_in = ov_ff && rsp_stall;
      q_take = 1'b0; we = 1'b0; waddr = '0; wdata = '0; raddr = old_ff;
      tr = '0; d2 = '0; nr = '0; dy = '0; yw = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !ov_in) begin
               q_take = 1'b1; cur_in = q_data;
               out_in = '0;
               unique case (q_data.kind)
                  KIND_PUSH: state_in = ST_PUSH_WR;
                  KIND_INTERP: begin
                     if (cnt_ff < CW'(2)) state_in = ST_OUT;
                     else state_in = ST_Q_RD;
                  end
                  KIND_LATEST: begin
                     if (cnt_ff == '0) state_in = ST_OUT;
                     else state_in = ST_LAT_RD;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_PUSH_WR: begin
            if (cnt_ff == DEPTH_C) begin
               we = 1'b1; waddr = old_ff;
               old_in = slot(old_ff, CW'(1));
            end else begin
               we = 1'b1; waddr = slot(old_ff, cnt_ff); cnt_in = cnt_ff + CW'(1);
            end
            wdata = {cur_ff.time_ns, cur_ff.roll_in, cur_ff.pitch_in, cur_ff.yaw_in};
            out_in.ok = 1'b1;
            state_in = ST_EVICT_RD;
         end
         ST_EVICT_RD: begin
            raddr = old_ff;
            if (cnt_ff > CW'(2)) state_in = ST_EVICT_CHK;
            else state_in = ST_OUT;
         end
         ST_EVICT_CHK: begin
            // Signed compare of stored time against push time minus window.
            tr = {1'b0, cur_ff.time_ns} - {32'd0, window_ns};
            if ($signed({1'b0, rd_t}) < $signed(tr)) begin
               old_in = slot(old_ff, CW'(1)); cnt_in = cnt_ff - CW'(1);
               state_in = ST_EVICT_RD;
            end else state_in = ST_OUT;
         end
         ST_LAT_RD: begin
            raddr = slot(old_ff, cnt_ff - CW'(1)); state_in = ST_LAT_WAIT;
         end
         ST_LAT_WAIT: begin
            out_in.ok = 1'b1; out_in.roll_out = rd_r; out_in.pitch_out = rd_p;
            out_in.yaw_out = rd_y; out_in.time_out = rd_t; state_in = ST_OUT;
         end
         ST_Q_RD: begin
            raddr = slot(old_ff, cnt_ff - CW'(1)); state_in = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            // Newest time check, then the first read of the scan is the oldest.
            raddr = old_ff; hi_in = '0;
            if (cur_ff.time_ns > rd_t) state_in = ST_OUT;
            else state_in = ST_SCAN_CHK;
         end
         ST_SCAN_RD: begin
            raddr = slot(old_ff, hi_ff); state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (hi_ff == '0) begin
               if (cur_ff.time_ns < rd_t) state_in = ST_OUT;
               else begin
                  hi_in = CW'(1); state_in = ST_SCAN_RD;
               end
            end else if (rd_t < cur_ff.time_ns) begin
               ta_in = rd_t; ra_in = rd_r; pa_in = rd_p; ya_in = rd_y;
               hi_in = hi_ff + CW'(1);
               if (hi_ff + CW'(1) >= cnt_ff) state_in = ST_OUT;
               else state_in = ST_SCAN_RD;
            end else begin
               tb_in = rd_t; rb_in = rd_r; pb_in = rd_p; yb_in = rd_y;
               state_in = ST_PAIR;
            end
            if (hi_ff == '0) begin
               ta_in = rd_t; ra_in = rd_r; pa_in = rd_p; ya_in = rd_y;
            end
         end
         ST_PAIR: begin
            if (tb_ff <= ta_ff) state_in = ST_OUT;
            else begin
               den_in = tb_ff - ta_ff; num_in = cur_ff.time_ns - ta_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (den_ff[62:47] != '0) begin
               den_in = den_ff >> 1; num_in = num_ff >> 1;
            end else begin
               rem_in = '0; quo_in = '0; bit_in = 6'd63; state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division of num*65536 by den, one bit per cycle.
            rem_in = {rem_ff[62:0], (bit_ff >= 6'd16) ? num_ff[bit_ff - 6'd16] : 1'b0};
            quo_in = {quo_ff[15:0], 1'b0};
            if (rem_in >= {1'b0, den_ff}) begin
               rem_in = rem_in - {1'b0, den_ff};
               if (quo_ff[16] == 1'b0) quo_in[0] = 1'b1;
            end
            if (quo_ff[16]) quo_in = quo_ff;
            if (bit_ff == '0) state_in = ST_BLEND;
            else bit_in = bit_ff - 6'd1;
         end
         ST_BLEND: begin
            dy = wrap_once(18'(yb_ff) - 18'(ya_ff));
            ro_in = blend(ra_ff, 18'(rb_ff) - 18'(ra_ff), quo_ff);
            po_in = blend(pa_ff, 18'(pb_ff) - 18'(pa_ff), quo_ff);
            yo_in = blend(ya_ff, dy, quo_ff);
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            yw = wrap_once(yo_ff);
            out_in.ok = 1'b1; out_in.roll_out = ro_ff[15:0];
            out_in.pitch_out = po_ff[15:0]; out_in.yaw_out = yw[15:0];
            out_in.time_out = cur_ff.time_ns;
            d2 = {1'b0, tb_ff - ta_ff};
            out_in.bracket_ns = (d2[63:32] != '0) ? 32'hFFFFFFFF : d2[31:0];
            nr = {1'b0, cur_ff.time_ns - ta_ff};
            d2 = {1'b0, tb_ff - cur_ff.time_ns};
            if (d2 < nr) nr = d2;
            out_in.nearest_ns = (nr[63:32] != '0) ? 32'hFFFFFFFF : nr[31:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            ov_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; old_ff <= '0; cnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; old_ff <= old_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
      end
      cur_ff <= cur_in; hi_ff <= hi_in; ta_ff <= ta_in; tb_ff <= tb_in;
      ra_ff <= ra_in; pa_ff <= pa_in; ya_ff <= ya_in;
      rb_ff <= rb_in; pb_ff <= pb_in; yb_ff <= yb_in;
      den_ff <= den_in; num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in;
      bit_ff <= bit_in; ro_ff <= ro_in; po_ff <= po_in; yo_ff <= yo_in;
      out_ff <= out_in;
   end

   `TAI_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= DEPTH_C, "count overflow")
   `TAI_ASSERT_NEXT(a_rsp_hold, clock, reset, ov_ff && rsp_stall, ov_ff && $stable(out_ff),
      "response lost")
   `TAI_ASSERT_IMPL(a_take_idle, clock, reset, q_take, state_ff == ST_IDLE && !ov_in,
      "take while busy")
endmodule

### rtl/timestamped_attitude_interpolator_core.sv
// Channel | Ports            | Moves
// req     | req_valid/stall  | one push, interpolate or latest request
// rsp     | rsp_valid/stall  | one response per request
// csr     | csr_we/csr_wdata | window_ns register
// A push writes the sample, then reads and checks the oldest sample once per
// eviction; latest reads the newest sample. An interpolate runs a linear scan over
// the history port, the pre-divide shift and the bit-serial divider.
// Reset is synchronous and empties the history at once; stored samples stay.
// A two-entry request queue lets requests enter while the back end works, and
// the response register holds under rsp_stall.
module timestamped_attitude_interpolator_core #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tai_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tai_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);
   import tai_pkg::*;

   logic [31:0] window_ff;
   logic q_valid, q_take;
   req_type q_data;

   // Window register.
   always_ff @(posedge clock) begin
      if (reset) window_ff <= WINDOW_RESET;
      else if (csr_we) window_ff <= csr_wdata;
   end

   tai_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   tai_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock, .reset, .window_ns(window_ff), .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

### bench/attitude_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the interpolator, keeps its own copy of the sample
// history, predicts each response and compares it with what the block returns.
module attitude_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tai_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tai_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   output int               mismatch_count,
   output int               pending_count
);
   import tai_pkg::*;

   localparam int DEPTH = 256;

   logic [62:0]        hist_time  [DEPTH];
   logic signed [15:0] hist_roll  [DEPTH];
   logic signed [15:0] hist_pitch [DEPTH];
   logic signed [15:0] hist_yaw   [DEPTH];
   int                 oldest;
   int                 held;
   logic [31:0]        window;
   rsp_type            expected_rsp_q[$];

   assign pending_count = expected_rsp_q.size();

   function automatic int ring_slot(input int k);
      return (oldest + k) % DEPTH;
   endfunction

   // Brings an angle back into plus or minus pi.
   function automatic int wrap_pi(input int a);
      int r;
      r = a;
      while (r > 25736) r = r - 51472;
      while (r < -25736) r = r + 51472;
      return r;
   endfunction

   // Linear blend with half-up rounding of the unsigned Q1.16 fraction product.
   function automatic int blend_q(input int base, input int diff, input int u);
      longint p;
      p = longint'(diff) * longint'(u) + 64'sd32768;
      return base + int'(p >>> 16);
   endfunction

   function automatic longint unsigned sat_32(input longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   // Applies one request to the history copy and returns the expected response.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type            o;
      int                 s, hi, sa, sb, u;
      int                 ry, py, yy;
      longint unsigned    t, ta, tb, den, num, quo, nearest, d2;
      longint             evict_limit;
      o = '0;
      t = longint'(r.time_ns);
      case (r.kind)
         KIND_PUSH: begin
            if (held >= DEPTH) begin
               oldest = ring_slot(1);
               held--;
            end
            s = ring_slot(held);
            hist_time[s]  = r.time_ns;
            hist_roll[s]  = r.roll_in;
            hist_pitch[s] = r.pitch_in;
            hist_yaw[s]   = r.yaw_in;
            held++;
            evict_limit = longint'(t) - longint'({32'd0, window});
            while (held > 2 && longint'({1'b0, hist_time[oldest]}) < evict_limit) begin
               oldest = ring_slot(1);
               held--;
            end
            o.ok = 1'b1;
         end
         KIND_LATEST: begin
            if (held != 0) begin
               s = ring_slot(held - 1);
               o.ok        = 1'b1;
               o.roll_out  = hist_roll[s];
               o.pitch_out = hist_pitch[s];
               o.yaw_out   = hist_yaw[s];
               o.time_out  = hist_time[s];
            end
         end
         KIND_INTERP: begin
            if (held < 2) return o;
            if (t < hist_time[ring_slot(0)] || t > hist_time[ring_slot(held - 1)]) return o;
            hi = 1;
            while (hi < held && hist_time[ring_slot(hi)] < t) hi++;
            if (hi >= held) return o;
            sa = ring_slot(hi - 1);
            sb = ring_slot(hi);
            ta = hist_time[sa];
            tb = hist_time[sb];
            if (tb <= ta) return o;
            den = tb - ta;
            num = t - ta;
            while (den >= 64'h8000_0000_0000) begin
               den = den >> 1;
               num = num >> 1;
            end
            quo = (num << 16) / den;
            u = (quo > 65536) ? 65536 : int'(quo);
            ry = blend_q(hist_roll[sa], int'(hist_roll[sb]) - int'(hist_roll[sa]), u);
            py = blend_q(hist_pitch[sa], int'(hist_pitch[sb]) - int'(hist_pitch[sa]), u);
            yy = blend_q(hist_yaw[sa],
                         wrap_pi(int'(hist_yaw[sb]) - int'(hist_yaw[sa])), u);
            yy = wrap_pi(yy);
            nearest = t - ta;
            d2 = (tb >= t) ? tb - t : t - tb;
            if (d2 < nearest) nearest = d2;
            o.ok         = 1'b1;
            o.roll_out   = 16'(ry);
            o.pitch_out  = 16'(py);
            o.yaw_out    = 16'(yy);
            o.time_out   = r.time_ns;
            o.bracket_ns = 32'(sat_32(tb - ta));
            o.nearest_ns = 32'(sat_32(nearest));
         end
         default: ;
      endcase
      return o;
   endfunction

   // Predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         oldest = 0;
         held = 0;
         window = WINDOW_RESET;
         mismatch_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_we) window = csr_wdata;
         if (req_valid && !req_stall) begin
            want = predict_response(req_data);
            expected_rsp_q = {expected_rsp_q, want};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsp_q[0];
               expected_rsp_q.delete(0);
               if (want.ok != rsp_data.ok || want.roll_out != rsp_data.roll_out ||
                   want.pitch_out != rsp_data.pitch_out ||
                   want.yaw_out != rsp_data.yaw_out ||
                   want.time_out != rsp_data.time_out ||
                   want.bracket_ns != rsp_data.bracket_ns ||
                   want.nearest_ns != rsp_data.nearest_ns) begin
                  if (mismatch_count < 10) begin
                     $display("mismatch exp ok=%0d r=%0d p=%0d y=%0d t=%0d br=%0d nr=%0d",
                              want.ok, want.roll_out, want.pitch_out, want.yaw_out,
                              want.time_out, want.bracket_ns, want.nearest_ns);
                     $display("         got ok=%0d r=%0d p=%0d y=%0d t=%0d br=%0d nr=%0d",
                              rsp_data.ok, rsp_data.roll_out, rsp_data.pitch_out,
                              rsp_data.yaw_out, rsp_data.time_out, rsp_data.bracket_ns,
                              rsp_data.nearest_ns);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tai_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          pending_count;

   logic            quiet;
   int              request_count;
   int              rsp_hold;
   longint unsigned now_ns;

   timestamped_attitude_interpolator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   attitude_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Run limit well beyond the slowest legal run.
   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: hold stall for a random number of cycles per response.
   initial begin
      rsp_stall = 1'b0;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) rsp_hold = quiet ? 0 : $urandom_range(0, 18);
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sends one request after a random gap and returns once it is accepted.
   task automatic send_request(input logic [1:0] k, input longint unsigned t,
                               input logic [15:0] r, input logic [15:0] p,
                               input logic [15:0] y);
      int gap;
      if (request_count % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      request_count++;
      gap = quiet ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: k, time_ns: t[62:0], roll_in: r, pitch_in: p, yaw_in: y};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic push_sample(input longint unsigned t);
      send_request(KIND_PUSH, t, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Changes the window once every outstanding request has been answered.
   task automatic write_window(input logic [31:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly ordered pushes with queries inside the held span, plus noise.
   task automatic run_phase(input logic [31:0] win, input int n, input int unsigned max_step);
      int              pick;
      longint unsigned back;
      write_window(win);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            now_ns = now_ns + $urandom_range(0, max_step);
            push_sample(now_ns);
         end else if (pick < 60) begin
            back = $urandom_range(0, max_step);
            push_sample((back < now_ns) ? now_ns - back : 0);
         end else if (pick < 85) begin
            back = longint'($urandom_range(0, max_step)) * 4;
            send_request(KIND_INTERP, (back < now_ns) ? now_ns - back : 0, 0, 0, 0);
         end else if (pick < 90) begin
            send_request(KIND_INTERP, now_ns + $urandom_range(0, 1), 0, 0, 0);
         end else if (pick < 96) begin
            send_request(KIND_LATEST, now_ns, 0, 0, 0);
         end else begin
            send_request(KIND_UNUSED, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                         16'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      quiet = 1'b0;
      request_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty history, unused kind, then a single sample.
      send_request(KIND_LATEST, 0, 0, 0, 0);
      send_request(KIND_INTERP, 5, 0, 0, 0);
      send_request(KIND_UNUSED, 63'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(KIND_PUSH, 1000, 16'sd32767, 16'sh8000, 16'sd25736);
      send_request(KIND_INTERP, 1000, 0, 0, 0);
      // Extreme differences and yaw wrapping across pi.
      send_request(KIND_PUSH, 2000, 16'sh8000, 16'sd32767, -16'sd25736);
      send_request(KIND_INTERP, 1500, 0, 0, 0);
      send_request(KIND_INTERP, 1000, 0, 0, 0);
      send_request(KIND_INTERP, 2000, 0, 0, 0);
      send_request(KIND_INTERP, 999, 0, 0, 0);
      send_request(KIND_INTERP, 2001, 0, 0, 0);
      send_request(KIND_LATEST, 0, 0, 0, 0);
      // Repeated stamp, then a sample out of order.
      send_request(KIND_PUSH, 2000, 16'sd100, -16'sd100, 16'sd32767);
      send_request(KIND_PUSH, 3000, -16'sd5, 16'sd7, 16'sh8000);
      send_request(KIND_PUSH, 1500, 16'sd1, 16'sd2, 16'sd3);
      send_request(KIND_PUSH, 4000, 16'sd9, 16'sd8, 16'sd7);
      send_request(KIND_INTERP, 3500, 0, 0, 0);
      send_request(KIND_INTERP, 2000, 0, 0, 0);

      // A zero window leaves only two equal stamps, so the span is empty.
      write_window(32'd0);
      send_request(KIND_PUSH, 5000, 16'sd10, 16'sd20, 16'sd30);
      send_request(KIND_PUSH, 5000, 16'sd11, 16'sd21, 16'sd31);
      send_request(KIND_INTERP, 5000, 0, 0, 0);

      // Spans that saturate and force the pre-divide shift.
      write_window(32'hFFFF_FFFF);
      push_sample(0);
      push_sample(63'h7FFF_FFFF_FFFF_FFFF);
      send_request(KIND_INTERP, {$urandom, $urandom} >> 1, 0, 0, 0);
      send_request(KIND_INTERP, 63'h7FFF_FFFF_FFFF_FFFE, 0, 0, 0);
      send_request(KIND_LATEST, 0, 0, 0, 0);

      // Random phases over several windows.
      now_ns = 64'd10_000;
      run_phase(32'hFFFF_FFFF, 200, 32'h8000_0000);
      run_phase(32'd0, 200, 1000);
      begin
         logic [31:0] w;
         w = $urandom;
         run_phase(w, 200, (w >> 2) + 1);
      end
      run_phase(32'd1, 200, 3);

      // Fill the history past its depth, then query the full ring.
      write_window(32'hFFFF_FFFF);
      repeat (270) begin
         now_ns = now_ns + $urandom_range(0, 3);
         push_sample(now_ns);
      end
      run_phase(32'hFFFF_FFFF, 120, 3);

      // Times with the upper bits set.
      now_ns = 64'h4000_0000_0000_0000 | {$urandom, $urandom} >> 3;
      run_phase(WINDOW_RESET, 200, 32'h4000_0000);
      run_phase($urandom, 200, $urandom);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
